// ===== rtl/sparse_polynomial_add_merge_assert.svh =====
// assertion macros for the sparse polynomial add merge block
`ifndef SPARSE_POLYNOMIAL_ADD_MERGE_ASSERT_SVH
`define SPARSE_POLYNOMIAL_ADD_MERGE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SPM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define SPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== rtl/spm_pkg.sv =====
// shared types and constants for the sparse polynomial add merge block
`default_nettype none

package spm_pkg;

  localparam int TERMS_MAX = 16;
  localparam int IDX_W     = (TERMS_MAX > 1) ? $clog2(TERMS_MAX) : 1;
  localparam int CNT_W     = $clog2(TERMS_MAX + 1);
  localparam int OP_W      = 2;
  localparam int COEF_W    = 16;
  localparam int EXP_W     = 16;
  localparam int SUM_W     = COEF_W + 1;
  localparam int TERM_W    = COEF_W + EXP_W;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_APPEND_A = op_t'(0);
  localparam op_t OP_APPEND_B = op_t'(1);
  localparam op_t OP_MERGE    = op_t'(2);

  typedef struct packed {
    op_t                      op;
    logic signed [COEF_W-1:0] term_coef;
    logic [EXP_W-1:0]         term_exp;
  } cmd_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_coef;
    logic [EXP_W-1:0]        sum_exp;
    logic                    run_last;
    logic                    empty_result;
    logic                    dropped;
  } result_t;

  // stored term: exponent in the upper half, coefficient in the lower half
  typedef struct packed {
    logic [EXP_W-1:0]         term_exp;
    logic signed [COEF_W-1:0] term_coef;
  } term_t;

  typedef struct packed {
    logic             go;
    logic [CNT_W-1:0] count_a;
    logic [CNT_W-1:0] count_b;
    logic             dropped;
  } merge_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [IDX_W-1:0] addr_a;
    logic [IDX_W-1:0] addr_b;
  } merge_stat_t;

endpackage

`default_nettype wire

// ===== rtl/sparse_polynomial_add_merge.sv =====
// top level of the sparse polynomial add merge block
//
//   channel   | signals              | transfer when
//   ----------+----------------------+---------------------------
//   command   | start, busy, command | start high and busy low
//   result    | valid, result        | valid high, one cycle each
//
// appends of terms to list a or b may arrive in every cycle while no merge
// is running; busy stays low for them
// a merge holds busy while it walks s <= count_a + count_b compare steps
// and a final step that closes the run; each step is a read of the two term
// rams followed by a compare and add
// results come only from step states, between fetches; the receiver cannot stall
// synchronous active-high reset clears the counts and the overflow flag; the
// term rams are not cleared, only entries below the counts are used
`default_nettype none

`include "sparse_polynomial_add_merge_assert.svh"

module sparse_polynomial_add_merge (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire spm_pkg::cmd_t    command,
  output logic                  valid,
  output spm_pkg::result_t      result
);

  logic [spm_pkg::CNT_W-1:0] count_a;
  logic [spm_pkg::CNT_W-1:0] count_b;
  logic                      overflow_seen;

  logic                 accept;
  logic                 is_append_a;
  logic                 is_append_b;
  logic                 coef_nonzero;
  logic                 full_a;
  logic                 full_b;
  logic                 wr_en_a;
  logic                 wr_en_b;
  spm_pkg::term_t       wr_term;
  spm_pkg::term_t       rd_a;
  spm_pkg::term_t       rd_b;
  spm_pkg::merge_req_t  merge_req;
  spm_pkg::merge_stat_t merge_stat;

  // command transfer
  assign accept = start && !busy;
  assign busy   = merge_stat.busy;

  // append decode: zero coefficients are dropped, full lists flag overflow
  assign is_append_a  = accept && (command.op == spm_pkg::OP_APPEND_A);
  assign is_append_b  = accept && (command.op == spm_pkg::OP_APPEND_B);
  assign coef_nonzero = command.term_coef != '0;
  assign full_a       = count_a >= spm_pkg::CNT_W'(spm_pkg::TERMS_MAX);
  assign full_b       = count_b >= spm_pkg::CNT_W'(spm_pkg::TERMS_MAX);
  assign wr_en_a      = is_append_a && coef_nonzero && !full_a;
  assign wr_en_b      = is_append_b && coef_nonzero && !full_b;

  assign wr_term.term_exp  = command.term_exp;
  assign wr_term.term_coef = command.term_coef;

  // counts and flag stay put during a merge since busy blocks appends, until done clears them
  always_ff @(posedge clk) begin
    if (rst) begin
      count_a       <= '0;
      count_b       <= '0;
      overflow_seen <= 1'b0;
    end else if (merge_stat.done) begin
      count_a       <= '0;
      count_b       <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (wr_en_a) begin
        count_a <= count_a + spm_pkg::CNT_W'(1);
      end
      if (wr_en_b) begin
        count_b <= count_b + spm_pkg::CNT_W'(1);
      end
      if ((is_append_a && coef_nonzero && full_a) ||
          (is_append_b && coef_nonzero && full_b)) begin
        overflow_seen <= 1'b1;
      end
    end
  end

  // list a storage, written at the fill count, read at the merge index
  spm_ram #(
    .WIDTH (spm_pkg::TERM_W),
    .DEPTH (spm_pkg::TERMS_MAX)
  ) u_ram_a (
    .clk     (clk),
    .wr_en   (wr_en_a),
    .wr_addr (count_a[spm_pkg::IDX_W-1:0]),
    .wr_data (wr_term),
    .rd_addr (merge_stat.addr_a),
    .rd_data (rd_a)
  );

  // list b storage
  spm_ram #(
    .WIDTH (spm_pkg::TERM_W),
    .DEPTH (spm_pkg::TERMS_MAX)
  ) u_ram_b (
    .clk     (clk),
    .wr_en   (wr_en_b),
    .wr_addr (count_b[spm_pkg::IDX_W-1:0]),
    .wr_data (wr_term),
    .rd_addr (merge_stat.addr_b),
    .rd_data (rd_b)
  );

  // merge kicks off on an accepted merge command
  assign merge_req.go      = accept && (command.op == spm_pkg::OP_MERGE);
  assign merge_req.count_a = count_a;
  assign merge_req.count_b = count_b;
  assign merge_req.dropped = overflow_seen;

  spm_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .req    (merge_req),
    .term_a (rd_a),
    .term_b (rd_b),
    .stat   (merge_stat),
    .valid  (valid),
    .result (result)
  );

  // the final result of a run lands just as the sequencer goes idle
  `SPM_ASSERT_NOW(a_last_idle, valid && result.run_last, !busy)
  // earlier results of a run come while the merge is still going
  `SPM_ASSERT_NOW(a_mid_busy, valid && !result.run_last, busy)
  // an empty sum is a single zero term that closes the run
  `SPM_ASSERT_NOW(a_empty_form, valid && result.empty_result, result.run_last && result.sum_coef == '0 && result.sum_exp == '0)
  // lists and flag are cleared once a merge completes
  `SPM_ASSERT_NEXT(a_clear_after, merge_stat.done, count_a == '0 && count_b == '0 && !overflow_seen)

endmodule

`default_nettype wire

// ===== rtl/spm_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module spm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/spm_merge.sv =====
// merge sequencer: walks both term lists and emits the sum terms
`default_nettype none

module spm_merge (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire spm_pkg::merge_req_t  req,
  input  wire spm_pkg::term_t       term_a,
  input  wire spm_pkg::term_t       term_b,
  output spm_pkg::merge_stat_t      stat,
  output logic                      valid,
  output spm_pkg::result_t          result
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_STEP
  } state_t;

  state_t state;

  logic [spm_pkg::CNT_W-1:0] idx_a;
  logic [spm_pkg::CNT_W-1:0] idx_b;

  // one result is held back so the final one can carry run_last
  logic                              pend_valid;
  logic signed [spm_pkg::SUM_W-1:0]  pend_coef;
  logic [spm_pkg::EXP_W-1:0]         pend_exp;

  logic                              a_has;
  logic                              b_has;
  logic                              finish;
  logic                              take_a;
  logic                              take_b;
  logic                              cand_valid;
  logic signed [spm_pkg::SUM_W-1:0]  cand_coef;
  logic [spm_pkg::EXP_W-1:0]         cand_exp;
  logic signed [spm_pkg::SUM_W-1:0]  coef_a_ext;
  logic signed [spm_pkg::SUM_W-1:0]  coef_b_ext;
  logic signed [spm_pkg::SUM_W-1:0]  coef_sum;

  assign a_has  = idx_a < req.count_a;
  assign b_has  = idx_b < req.count_b;
  assign finish = !a_has && !b_has;

  assign coef_a_ext = {term_a.term_coef[spm_pkg::COEF_W-1], term_a.term_coef};
  assign coef_b_ext = {term_b.term_coef[spm_pkg::COEF_W-1], term_b.term_coef};
  assign coef_sum   = coef_a_ext + coef_b_ext;

  always_comb begin
    take_a     = 1'b0;
    take_b     = 1'b0;
    cand_valid = 1'b0;
    cand_coef  = coef_a_ext;
    cand_exp   = term_a.term_exp;
    if (a_has && b_has) begin
      if (term_a.term_exp > term_b.term_exp) begin
        take_a     = 1'b1;
        cand_valid = 1'b1;
      end else if (term_a.term_exp < term_b.term_exp) begin
        take_b     = 1'b1;
        cand_valid = 1'b1;
        cand_coef  = coef_b_ext;
        cand_exp   = term_b.term_exp;
      end else begin
        take_a     = 1'b1;
        take_b     = 1'b1;
        cand_valid = coef_sum != '0;
        cand_coef  = coef_sum;
      end
    end else if (a_has) begin
      take_a     = 1'b1;
      cand_valid = 1'b1;
    end else if (b_has) begin
      take_b     = 1'b1;
      cand_valid = 1'b1;
      cand_coef  = coef_b_ext;
      cand_exp   = term_b.term_exp;
    end
  end

  assign stat.busy   = state != S_IDLE;
  assign stat.done   = (state == S_STEP) && finish;
  assign stat.addr_a = idx_a[spm_pkg::IDX_W-1:0];
  assign stat.addr_b = idx_b[spm_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid      <= 1'b0;
      pend_valid <= 1'b0;
      idx_a      <= '0;
      idx_b      <= '0;
    end else begin
      valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.go) begin
            idx_a      <= '0;
            idx_b      <= '0;
            pend_valid <= 1'b0;
            state      <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_STEP;
        end
        S_STEP: begin
          if (finish) begin
            valid               <= 1'b1;
            result.run_last     <= 1'b1;
            result.dropped      <= req.dropped;
            result.empty_result <= !pend_valid;
            result.sum_coef     <= pend_valid ? pend_coef : '0;
            result.sum_exp      <= pend_valid ? pend_exp : '0;
            pend_valid          <= 1'b0;
            state               <= S_IDLE;
          end else begin
            if (take_a) begin
              idx_a <= idx_a + spm_pkg::CNT_W'(1);
            end
            if (take_b) begin
              idx_b <= idx_b + spm_pkg::CNT_W'(1);
            end
            if (cand_valid) begin
              if (pend_valid) begin
                valid               <= 1'b1;
                result.run_last     <= 1'b0;
                result.empty_result <= 1'b0;
                result.dropped      <= req.dropped;
                result.sum_coef     <= pend_coef;
                result.sum_exp      <= pend_exp;
              end
              pend_valid <= 1'b1;
              pend_coef  <= cand_coef;
              pend_exp   <= cand_exp;
            end
            state <= S_FETCH;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
